[src/lmf_pkg.sv]
`timescale 1ns / 1ps

package lmf_pkg;

	// Fixed field widths of the sample and result items.
	localparam int SAMPLE_W   = 32;
	localparam int ROW_IDX_W  = 10;
	localparam int COL_IDX_W  = 6;

	// Configuration register widths and the write port.
	localparam int NUM_ROWS_W = 11;
	localparam int NUM_COLS_W = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// One line store entry: the row two above and the row just above.
	typedef struct packed {
		sample_t older;
		sample_t prev;
	} line_word_t;

	// Result slots of one sample, in the order they leave the block.
	localparam int NUM_SLOTS  = 4;
	localparam int SLOT_ABOVE = 0;
	localparam int SLOT_LEFT  = 1;
	localparam int SLOT_HERE  = 2;
	localparam int SLOT_END   = 3;

	// Everything one sample hands to the result serializer.
	typedef struct packed {
		logic [NUM_SLOTS-1:0]  hit;
		sample_t               value_above;
		sample_t               value_left;
		sample_t               value_here;
		logic [ROW_IDX_W-1:0]  row;
		logic [COL_IDX_W-1:0]  col;
	} emit_bundle_t;

endpackage

[src/lmf_if.sv]
`timescale 1ns / 1ps

interface lmf_cfg_if import lmf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface lmf_sample_if import lmf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface lmf_result_if import lmf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	sample_t              value;
	logic [ROW_IDX_W-1:0] row_index;
	logic [COL_IDX_W-1:0] col_index;
	logic                 end_of_matrix;
	logic                 last_of_run;

	modport source (output valid, output value, output row_index, output col_index,
		output end_of_matrix, output last_of_run, input ready);
	modport sink (input valid, input value, input row_index, input col_index,
		input end_of_matrix, input last_of_run, output ready);
endinterface

[src/matrix_local_minimum_finder_unit.sv]
`timescale 1ns / 1ps
// Path: a transferred sample passes the decision stage register, then the result register,
// where its first result goes onto the output; either register can make it wait.
// Throughput: one sample per cycle while each sample yields at most one result that the sink
// takes at once; more results hold the single result register and can hold the input too.
// Reset: position counters clear, num_rows and num_cols return to 1; the line store memory
// is not cleared and holds nothing meaningful until written by the first rows.

module matrix_local_minimum_finder_unit import lmf_pkg::*; #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	lmf_cfg_if.sink      cfg,
	lmf_sample_if.sink   samples,
	lmf_result_if.source results
);

	// Address width of the line store; a one-column store still gets one bit.
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	typedef struct packed {
		logic r_ge1;
		logic r_ge2;
		logic c_ge1;
		logic c_ge2;
		logic last_row;
		logic last_col;
	} item_flags_t;

	// Configuration registers. The port never pushes back.
	logic [NUM_ROWS_W-1:0] num_rows_q;
	logic [NUM_COLS_W-1:0] num_cols_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= NUM_ROWS_W'(1);
			num_cols_q <= NUM_COLS_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_NUM_ROWS: num_rows_q <= cfg.data[NUM_ROWS_W-1:0];
				REG_NUM_COLS: num_cols_q <= cfg.data[NUM_COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage: the position counters say where the incoming sample sits. A register
	// value of zero acts as one, and a value above the store size acts as the store size,
	// which falls out of the "at or past the last" compares below.
	logic [NUM_ROWS_W-1:0] r_q;
	logic [CW-1:0]         c_q;
	item_flags_t           flags_s0;
	logic                  in_xfer;
	logic                  s1_adv;
	logic                  v_s1;

	always_comb begin
		flags_s0.r_ge1    = (r_q != '0);
		flags_s0.r_ge2    = (32'(r_q) >= 2);
		flags_s0.c_ge1    = (c_q != '0);
		flags_s0.c_ge2    = (32'(c_q) >= 2);
		flags_s0.last_row = (32'(r_q) + 1 >= 32'(num_rows_q)) || (32'(r_q) + 1 >= MAX_ROWS);
		flags_s0.last_col = (32'(c_q) + 1 >= 32'(num_cols_q)) || (32'(c_q) + 1 >= MAX_COLS);
	end

	assign samples.ready = !v_s1 || s1_adv;
	assign in_xfer       = samples.valid && samples.ready;

	// Raster order: step along the row, wrap to the next row, and start over after the
	// last element of the matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (in_xfer) begin
			if (flags_s0.last_row && flags_s0.last_col) begin
				r_q <= '0;
				c_q <= '0;
			end else if (flags_s0.last_col) begin
				r_q <= r_q + NUM_ROWS_W'(1);
				c_q <= '0;
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	// Decision stage. The sample waits here while the line store returns the column's two
	// stored rows and the right-hand neighbor of the row above.
	sample_t               sample_s1;
	logic [NUM_ROWS_W-1:0] r_s1;
	logic [CW-1:0]         c_s1;
	item_flags_t           flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_xfer) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= samples.sample;
			r_s1      <= r_q;
			c_s1      <= c_q;
			flags_s1  <= flags_s0;
		end
	end

	// The store is read when a sample is transferred and written back when that sample
	// leaves the decision stage: the row above moves into the older slot and the new
	// sample becomes the row above. Since the next sample is read on that same edge, the
	// store forwards the write when the columns coincide (one- and two-column matrices).
	line_word_t rd_word;
	line_word_t wr_word;
	sample_t    prev_next;
	sample_t    prev_c;
	sample_t    older_c;

	assign wr_word.older = prev_c;
	assign wr_word.prev  = sample_s1;

	lmf_line_store #(
		.DEPTH(MAX_COLS),
		.AW   (CW)
	) u_line_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (in_xfer),
		.rd_addr     (c_q),
		.rd_addr_next(flags_s0.last_col ? '0 : c_q + CW'(1)),
		.wr_en       (s1_adv),
		.wr_addr     (c_s1),
		.wr_data     (wr_word),
		.rd_word     (rd_word),
		.rd_next_prev(prev_next)
	);

	assign prev_c  = rd_word.prev;
	assign older_c = rd_word.older;

	// Columns are visited strictly in order, so the neighbors to the left come from small
	// history registers: left_q is the row-above element one column back, sp1_q and
	// sp2_q are the current row's previous two samples.
	sample_t left_q;
	sample_t sp1_q;
	sample_t sp2_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			left_q <= prev_c;
			sp1_q  <= sample_s1;
			sp2_q  <= sp1_q;
		end
	end

	// Three candidates per sample. The element above is settled now that its lower
	// neighbor is here. On the last row, the element to the left is settled by its right
	// neighbor, and the final sample settles itself and closes the matrix with a marker.
	logic         ok_above;
	logic         ok_left;
	logic         ok_here;
	emit_bundle_t bundle;
	logic         can_load;

	always_comb begin
		ok_above = (prev_c < sample_s1)
			&& (!flags_s1.r_ge2 || (prev_c < older_c))
			&& (!flags_s1.c_ge1 || (prev_c < left_q))
			&& (flags_s1.last_col || (prev_c < prev_next));
		ok_left = (sp1_q < sample_s1)
			&& (!flags_s1.r_ge1 || (sp1_q < left_q))
			&& (!flags_s1.c_ge2 || (sp1_q < sp2_q));
		ok_here = (!flags_s1.r_ge1 || (sample_s1 < prev_c))
			&& (!flags_s1.c_ge1 || (sample_s1 < sp1_q));

		bundle.hit[SLOT_ABOVE] = flags_s1.r_ge1 && ok_above;
		bundle.hit[SLOT_LEFT]  = flags_s1.last_row && flags_s1.c_ge1 && ok_left;
		bundle.hit[SLOT_HERE]  = flags_s1.last_row && flags_s1.last_col && ok_here;
		bundle.hit[SLOT_END]   = flags_s1.last_row && flags_s1.last_col;
		bundle.value_above     = prev_c;
		bundle.value_left      = sp1_q;
		bundle.value_here      = sample_s1;
		bundle.row             = ROW_IDX_W'(r_s1);
		bundle.col             = COL_IDX_W'(c_s1);
	end

	// A sample with nothing to report moves on at once; otherwise it waits until the
	// result register has room for its whole group.
	assign s1_adv = v_s1 && (~|bundle.hit || can_load);

	lmf_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.bundle  (bundle),
		.load    (s1_adv && |bundle.hit),
		.can_load(can_load),
		.results (results)
	);

	// The last element of a matrix sends the counters back to the origin.
	a_wrap_to_origin: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && flags_s0.last_row && flags_s0.last_col |=> (r_q == '0) && (c_q == '0))
		else $error("position counters did not return to the origin after the last element");

	// Within a row the column advances by exactly one per transferred sample.
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !flags_s0.last_col |=> c_q == $past(c_q) + CW'(1))
		else $error("column counter skipped within a row");

	// The end marker carries no coordinates and always closes its group.
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.end_of_matrix |-> results.last_of_run
			&& (results.value == '0) && (results.row_index == '0)
			&& (results.col_index == '0))
		else $error("end marker is malformed or not the last of its group");

	// A sample only leaves the decision stage if it entered or was already held there.
	a_leave_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> $past(in_xfer) || $past(v_s1))
		else $error("decision stage advanced without a sample");

endmodule

[src/lmf_line_store.sv]
`timescale 1ns / 1ps

module lmf_line_store import lmf_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] rd_addr_next,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  line_word_t    wr_data,
	output line_word_t    rd_word,
	output sample_t       rd_next_prev
);

	line_word_t mem [DEPTH];
	line_word_t rd_word_q;
	sample_t    rd_next_q;
	line_word_t byp_data_q;
	logic       byp_word_q;
	logic       byp_next_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q  <= mem[rd_addr];
			rd_next_q  <= mem[rd_addr_next].prev;
			byp_data_q <= wr_data;
		end
	end

	// A write landing on the same edge as the read wins over the old contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_word_q <= 1'b0;
			byp_next_q <= 1'b0;
		end else if (rd_en) begin
			byp_word_q <= wr_en && (wr_addr == rd_addr);
			byp_next_q <= wr_en && (wr_addr == rd_addr_next);
		end
	end

	assign rd_word      = byp_word_q ? byp_data_q : rd_word_q;
	assign rd_next_prev = byp_next_q ? byp_data_q.prev : rd_next_q;

endmodule

[src/lmf_emitter.sv]
`timescale 1ns / 1ps

module lmf_emitter import lmf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  emit_bundle_t bundle,
	input  logic         load,
	output logic         can_load,
	lmf_result_if.source results
);

	logic [NUM_SLOTS-1:0] hit_q;
	logic [NUM_SLOTS-1:0] first;
	logic [NUM_SLOTS-1:0] rest;
	emit_bundle_t         data_q;

	// Lowest pending slot goes out first.
	assign first = hit_q & (~hit_q + NUM_SLOTS'(1));
	assign rest  = hit_q & ~first;

	assign results.valid       = |hit_q;
	assign results.last_of_run = ~|rest;
	assign can_load            = ~|hit_q || (~|rest && results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (load) begin
			hit_q <= bundle.hit;
		end else if (results.valid && results.ready) begin
			hit_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= bundle;
		end
	end

	always_comb begin
		results.value         = '0;
		results.row_index     = '0;
		results.col_index     = '0;
		results.end_of_matrix = 1'b0;
		if (first[SLOT_ABOVE]) begin
			results.value     = data_q.value_above;
			results.row_index = data_q.row - ROW_IDX_W'(1);
			results.col_index = data_q.col;
		end else if (first[SLOT_LEFT]) begin
			results.value     = data_q.value_left;
			results.row_index = data_q.row;
			results.col_index = data_q.col - COL_IDX_W'(1);
		end else if (first[SLOT_HERE]) begin
			results.value     = data_q.value_here;
			results.row_index = data_q.row;
			results.col_index = data_q.col;
		end else if (first[SLOT_END]) begin
			results.end_of_matrix = 1'b1;
		end
	end

endmodule

[bench/matrix_local_minimum_finder_unit_test.sv]
`timescale 1ns / 1ps

module matrix_local_minimum_finder_unit_test;
	import lmf_pkg::*;

	localparam int COLS_MAX      = 64;
	localparam int ROWS_MAX      = 1024;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 8;
	// Samples in the random part, the tall matrix included.
	localparam int RANDOM_ITEMS  = 230;
	// The sink refuses results this long once, so the block backs up into its input.
	localparam int HOLD_CYCLES   = 150;
	// Settle time after the drain, so the block has nothing in flight.
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 10;
	// Far above the long hold and any run of random idles.
	localparam int STALL_LIMIT   = 2000;

	localparam sample_t MOST_NEG = 32'sh8000_0000;
	localparam sample_t MOST_POS = 32'sh7FFF_FFFF;

	// How the values of one matrix are drawn. A tight spread gives many ties and many minima.
	typedef enum int {
		SPREAD_TIGHT,
		SPREAD_FULL,
		SPREAD_EDGES
	} spread_t;

	// One result of the block, as it leaves the result channel.
	typedef struct {
		sample_t              value;
		logic [ROW_IDX_W-1:0] row;
		logic [COL_IDX_W-1:0] col;
		logic                 eom;
		logic                 last;
	} minimum_t;

	// The scoreboard carries its own copy of the line stores, the position counters and
	// the two size registers. Every sample transfer is run through that copy to produce
	// the minima it should cause, and each result transfer is checked against the oldest
	// of them.
	class minimum_scoreboard;
		sample_t               older_line [COLS_MAX];
		sample_t               prev_line [COLS_MAX];
		sample_t               left_val;
		int unsigned           row_pos;
		int unsigned           col_pos;
		logic [NUM_ROWS_W-1:0] rows_reg;
		logic [NUM_COLS_W-1:0] cols_reg;
		minimum_t              expected_minima [$];
		int                    mismatch_count;

		function new();
			foreach (older_line[k]) begin
				older_line[k] = '0;
				prev_line[k]  = '0;
			end
			left_val       = '0;
			row_pos        = 0;
			col_pos        = 0;
			rows_reg       = 1;
			cols_reg       = 1;
			mismatch_count = 0;
		endfunction

		function int unsigned eff_rows();
			if (rows_reg == 0)
				return 1;
			if (rows_reg > ROWS_MAX)
				return ROWS_MAX;
			return rows_reg;
		endfunction

		function int unsigned eff_cols();
			if (cols_reg == 0)
				return 1;
			if (cols_reg > COLS_MAX)
				return COLS_MAX;
			return cols_reg;
		endfunction

		function int unsigned cells();
			return eff_rows() * eff_cols();
		endfunction

		function int pending();
			return expected_minima.size();
		endfunction

		function void note_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_NUM_ROWS)
				rows_reg = data[NUM_ROWS_W-1:0];
			else
				cols_reg = data[NUM_COLS_W-1:0];
		endfunction

		function minimum_t make_minimum(sample_t v, int unsigned r, int unsigned c, bit eom);
			minimum_t m;
			m.value = v;
			m.row   = r[ROW_IDX_W-1:0];
			m.col   = c[COL_IDX_W-1:0];
			m.eom   = eom;
			m.last  = 1'b0;
			return m;
		endfunction

		function void note_sample(sample_t s);
			int unsigned r_lim;
			int unsigned c_lim;
			int unsigned r;
			int unsigned c;
			sample_t     center;
			bit          ok;
			bit          last_row;
			bit          last_col;
			minimum_t    found [$];

			r_lim    = eff_rows();
			c_lim    = eff_cols();
			r        = row_pos;
			c        = col_pos;
			last_row = (r + 1 >= r_lim);
			last_col = (c + 1 >= c_lim);

			// The element straight above now has its lower neighbour.
			if (r >= 1) begin
				center = prev_line[c];
				ok = center < s;
				if (r >= 2)
					ok = ok && (center < older_line[c]);
				if (c >= 1)
					ok = ok && (center < left_val);
				if (c + 1 < c_lim)
					ok = ok && (center < prev_line[c + 1]);
				if (ok)
					found.push_back(make_minimum(center, r - 1, c, 1'b0));
			end

			left_val      = prev_line[c];
			older_line[c] = prev_line[c];
			prev_line[c]  = s;

			// On the bottom row the element to the left is complete as well.
			if (last_row && c >= 1) begin
				center = prev_line[c - 1];
				ok = center < s;
				if (r >= 1)
					ok = ok && (center < older_line[c - 1]);
				if (c >= 2)
					ok = ok && (center < prev_line[c - 2]);
				if (ok)
					found.push_back(make_minimum(center, r, c - 1, 1'b0));
			end

			if (last_row && last_col) begin
				ok = 1'b1;
				if (r >= 1)
					ok = s < older_line[c];
				if (c >= 1)
					ok = ok && (s < prev_line[c - 1]);
				if (ok)
					found.push_back(make_minimum(s, r, c, 1'b0));
				found.push_back(make_minimum('0, 0, 0, 1'b1));
				row_pos = 0;
				col_pos = 0;
			end else if (last_col) begin
				col_pos = 0;
				row_pos = r + 1;
			end else begin
				col_pos = c + 1;
			end

			if (found.size() > 0)
				found[found.size() - 1].last = 1'b1;
			foreach (found[k])
				expected_minima.push_back(found[k]);
		endfunction

		task report_mismatch(string msg);
			mismatch_count++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(minimum_t got);
			minimum_t want;
			if (expected_minima.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d row=%0d col=%0d end=%0b",
					got.value, got.row, got.col, got.eom));
				return;
			end
			want = expected_minima.pop_front();
			if (got.value !== want.value)
				report_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
			if (got.row !== want.row)
				report_mismatch($sformatf("row_index %0d, expected %0d", got.row, want.row));
			if (got.col !== want.col)
				report_mismatch($sformatf("col_index %0d, expected %0d", got.col, want.col));
			if (got.eom !== want.eom)
				report_mismatch($sformatf("end_of_matrix %b, expected %b", got.eom, want.eom));
			if (got.last !== want.last)
				report_mismatch($sformatf("last_of_run %b, expected %b", got.last, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lmf_cfg_if    cfg_bus ();
	lmf_sample_if sample_bus ();
	lmf_result_if result_bus ();

	minimum_scoreboard sb;

	int samples_sent = 0;
	int results_seen = 0;
	bit long_hold_wanted = 1'b0;

	matrix_local_minimum_finder_unit #(
		.MAX_COLS(COLS_MAX),
		.MAX_ROWS(ROWS_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.samples(sample_bus),
		.results(result_bus)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Each side idles about a quarter of the time, except inside one window of its own
	// where it runs flat out.
	function automatic bit sender_idles();
		if (samples_sent >= 150 && samples_sent < 320)
			return 1'b0;
		return $urandom_range(99) < 26;
	endfunction

	function automatic bit receiver_idles();
		if (results_seen >= 40 && results_seen < 120)
			return 1'b0;
		return $urandom_range(99) < 26;
	endfunction

	function automatic sample_t pick_sample(spread_t spread);
		case (spread)
			SPREAD_TIGHT: return sample_t'($urandom_range(6)) - 3;
			SPREAD_FULL:  return sample_t'($urandom);
			default: begin
				case ($urandom_range(5))
					0:       return MOST_NEG;
					1:       return MOST_NEG + 1;
					2:       return MOST_POS;
					3:       return MOST_POS - 1;
					4:       return '0;
					default: return sample_t'($urandom);
				endcase
			end
		endcase
	endfunction

	// Offers one sample and waits for its transfer. The valid line stays high afterwards,
	// so back-to-back samples go out without a bubble unless the sender chooses to idle.
	task automatic send_sample(input sample_t s);
		while (sender_idles()) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid  <= 1'b1;
		sample_bus.sample <= s;
		@(posedge clk);
		while (!sample_bus.ready)
			@(posedge clk);
		sb.note_sample(s);
		samples_sent++;
	endtask

	task automatic send_list(input sample_t vals [$]);
		foreach (vals[k])
			send_sample(vals[k]);
	endtask

	task automatic send_matrix(input spread_t spread);
		repeat (sb.cells())
			send_sample(pick_sample(spread));
	endtask

	// Holds the input back until every predicted result has come out, then lets the
	// pipeline settle, so that the size registers can be changed safely.
	task automatic drain_and_settle();
		sample_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Writes both size registers, in a random order.
	task automatic configure(input logic [CFG_DATA_W-1:0] rows_data,
		input logic [CFG_DATA_W-1:0] cols_data);
		cfg_reg_t              order [2];
		logic [CFG_DATA_W-1:0] word;
		if ($urandom_range(1)) begin
			order[0] = REG_NUM_ROWS;
			order[1] = REG_NUM_COLS;
		end else begin
			order[0] = REG_NUM_COLS;
			order[1] = REG_NUM_ROWS;
		end
		foreach (order[k]) begin
			word = (order[k] == REG_NUM_ROWS) ? rows_data : cols_data;
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= order[k];
			cfg_bus.data  <= word;
			@(posedge clk);
			while (!cfg_bus.ready)
				@(posedge clk);
			sb.note_register(order[k], word);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	// Result sink. A transfer is taken at the edge where valid and ready are both high;
	// the values read right after the edge are the ones the flops held at it. Once the
	// tall matrix starts, ready is held low for a long count so the block fills up.
	initial begin : result_sink
		int       hold_left;
		bit       held;
		minimum_t got;
		hold_left = 0;
		held      = 1'b0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				got.value = result_bus.value;
				got.row   = result_bus.row_index;
				got.col   = result_bus.col_index;
				got.eom   = result_bus.end_of_matrix;
				got.last  = result_bus.last_of_run;
				sb.check_result(got);
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else if (long_hold_wanted && !held) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= !receiver_idles();
			end
		end
	end

	// Ends the run when no transfer of any kind has happened for too long.
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int                    random_sent;
		bit                    tall_done;
		bit                    first_shape;
		int unsigned           rows;
		int unsigned           cols;
		logic [CFG_DATA_W-1:0] cols_data;
		spread_t               spread;

		sb = new();
		arst_n            <= 1'b0;
		sample_bus.valid  <= 1'b0;
		sample_bus.sample <= '0;
		cfg_bus.valid     <= 1'b0;
		cfg_bus.index     <= REG_NUM_ROWS;
		cfg_bus.data      <= '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Out of reset the matrix is 1x1, so each sample is its own
		// minimum followed by the end marker; the two most extreme values go first.
		send_list('{MOST_NEG});
		send_list('{MOST_POS});

		// Zero in both size registers still means a single element.
		drain_and_settle();
		configure(11'd0, 11'd0);
		send_list('{0});

		// 3x3 with a corner minimum, the center minimum and the final corner minimum.
		drain_and_settle();
		configure(11'd3, 11'd3);
		send_list('{-5, 1, 4, 2, 0, 2, 4, 1, -7});

		// A single row with equal neighbors: ties are never minima.
		drain_and_settle();
		configure(11'd1, 11'd4);
		send_list('{5, 5, 3, 7});

		// A single column, again with a tie.
		drain_and_settle();
		configure(11'd4, 11'd1);
		send_list('{2, -1, -1, -3});

		// The last sample decides the element above, the one to its left and ends the
		// matrix, so one sample yields three results.
		drain_and_settle();
		configure(11'd2, 11'd2);
		send_list('{3, 0, 0, 5});

		// Random part. Shapes change between matrices after a full drain; often the same
		// shape is kept so that matrices follow one another with no gap.
		random_sent = 0;
		tall_done   = 1'b0;
		first_shape = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			if (!tall_done && random_sent >= 100) begin
				// A tall single-column matrix. The sink stalls at its start while
				// samples keep coming.
				drain_and_settle();
				configure(11'd48, {4'($urandom_range(15)), 7'd1});
				long_hold_wanted = 1'b1;
				random_sent += sb.cells();
				send_matrix(SPREAD_TIGHT);
				tall_done   = 1'b1;
				first_shape = 1'b1;
			end else begin
				if (first_shape || $urandom_range(99) < 60) begin
					case ($urandom_range(9))
						0: begin
							rows = 0;
							cols = $urandom_range(8, 1);
						end
						1: begin
							rows = $urandom_range(4, 1);
							cols = 0;
						end
						2: begin
							rows = $urandom_range(2, 1);
							cols = COLS_MAX;
						end
						3: begin
							// Beyond the column limit, clamped down to it.
							rows = $urandom_range(2, 1);
							cols = 127;
						end
						4: begin
							rows = 1;
							cols = $urandom_range(16, 1);
						end
						5: begin
							rows = $urandom_range(16, 1);
							cols = 1;
						end
						default: begin
							rows = $urandom_range(6, 2);
							cols = $urandom_range(8, 2);
						end
					endcase
					// Bits above the column register's width carry junk; they are ignored.
					cols_data = {4'($urandom_range(15)), cols[NUM_COLS_W-1:0]};
					drain_and_settle();
					configure(rows[CFG_DATA_W-1:0], cols_data);
					first_shape = 1'b0;
				end
				case ($urandom_range(9))
					0, 1:    spread = SPREAD_FULL;
					2:       spread = SPREAD_EDGES;
					default: spread = SPREAD_TIGHT;
				endcase
				random_sent += sb.cells();
				send_matrix(spread);
			end
		end

		drain_and_settle();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
